>>> rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the LCS length engine
// Sizes of the cell row, value widths, request modes and the token that
// travels from cell to cell.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_LEN = 64;                    // cells in the row
  localparam int LEN_W   = $clog2(MAX_LEN + 1);   // fill count, 0..MAX_LEN
  localparam int SYM_W   = 8;
  localparam int VAL_W   = 7;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;       // saturation point

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_PROC   = 2'd1,
    MODE_FINISH = 2'd2
  } mode_e;

  // Wavefront token: second-string byte plus the two neighbor values.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] diag;   // old entry of the cell to the left
    logic [VAL_W-1:0] left;   // new entry of the cell to the left
  } tok_t;

endpackage

>>> rtl/core/lcs_length_engine_top.sv
// ----------------------------------------------------------------------------
// lcs_length_engine_top: longest common subsequence length engine
// Systolic row of cells computing the LCS length of two byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_axis: tuser carries the mode, tdata the byte.
//   Mode 0 appends a byte to the first string (dropped and flagged once the
//   string holds 64 bytes). Mode 1 feeds one second-string byte. Mode 2
//   emits the LCS length and overflow flag on m_axis and clears the job.
//   Mode 3 is taken and ignored.
// Throughput and latency:
//   Mode-1 bytes are accepted back to back, one per cycle; each byte walks
//   the 64-cell row one cell per cycle until its wavefront leaves the row.
//   Mode 0, mode 2 and mode 3 requests wait until the row has drained,
//   i.e. until the drain counter set by the last mode-1 byte reaches zero;
//   mode 2 also waits for a free output register. A mode-2 result appears
//   on m_axis the cycle after its request is accepted.
// Reset:
//   rst_ni clears the fill count, the overflow flag, all cell valid bits
//   and the in-flight tokens; the block is ready right after reset.
// Stall:
//   A result holds in the output register until m_axis_tready; meanwhile
//   mode-0 and mode-1 requests keep flowing, only another mode 2 waits.
// ----------------------------------------------------------------------------
module lcs_length_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [6:0] lcs_length, [7] overflowed
);
  import lcs_pkg::*;

  logic             acc;
  logic             is_load, is_proc, is_finish;
  logic             drained;
  logic             out_free;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] drain_q, drain_d;
  logic             ovf_q, ovf_d;
  logic [VAL_W-1:0] tail_q, tail_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;
  logic             do_load, do_clear;
  tok_t             tok [MAX_LEN+1];

  assign is_load   = (s_axis_tuser == MODE_LOAD);
  assign is_proc   = (s_axis_tuser == MODE_PROC);
  assign is_finish = (s_axis_tuser == MODE_FINISH);
  assign drained   = (drain_q == '0);
  assign out_free  = !out_valid_q || m_axis_tready;

  // Mode-1 bytes stream freely; loads and finishes wait for an empty row.
  assign s_axis_tready = is_proc || (drained && (!is_finish || out_free));
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign do_load       = acc && is_load && (len_q != LEN_W'(MAX_LEN));
  assign do_clear      = acc && is_finish;

  // Launch a wavefront token into cell 0.
  always_comb begin
    tok[0].valid = acc && is_proc;
    tok[0].sym   = s_axis_tdata;
    tok[0].diag  = '0;
    tok[0].left  = '0;
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lcs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (do_load && (len_q == LEN_W'(i))),
      .load_sym_i (s_axis_tdata),
      .clear_i    (do_clear),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  always_comb begin
    len_d       = len_q;
    drain_d     = drained ? drain_q : drain_q - LEN_W'(1);
    ovf_d       = ovf_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    // Token leaving the row carries the entry of the last valid cell.
    if (tok[MAX_LEN].valid) begin
      tail_d = tok[MAX_LEN].left;
    end
    if (acc && is_proc) begin
      drain_d = LEN_W'(MAX_LEN);
    end
    if (acc && is_load) begin
      if (do_load) begin
        len_d  = len_q + LEN_W'(1);
        tail_d = '0;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (do_clear) begin
      out_valid_d = 1'b1;
      out_data_d  = {ovf_q, tail_q};
      len_d       = '0;
      ovf_d       = 1'b0;
      tail_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      drain_q     <= '0;
      ovf_q       <= 1'b0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell: one position of the first string
// Holds one first-string byte and its row entry, updates the entry when a
// token passes and hands the token on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module lcs_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [lcs_pkg::SYM_W-1:0] load_sym_i,
  input  logic                  clear_i,
  input  lcs_pkg::tok_t         tok_i,
  output lcs_pkg::tok_t         tok_o
);
  import lcs_pkg::*;

  logic             valid_q, valid_d;
  logic [SYM_W-1:0] char_q, char_d;
  logic [VAL_W-1:0] row_q, row_d;
  tok_t             tok_q, tok_d;
  logic [VAL_W-1:0] nv;

  always_comb begin
    if (char_q == tok_i.sym) begin
      nv = (tok_i.diag == VAL_MAX) ? VAL_MAX : tok_i.diag + VAL_W'(1);
    end else begin
      nv = (row_q > tok_i.left) ? row_q : tok_i.left;
    end
  end

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    row_d   = row_q;
    tok_d   = tok_i;
    if (tok_i.valid && valid_q) begin
      row_d      = nv;
      tok_d.diag = row_q;
      tok_d.left = nv;
    end
    if (load_i) begin
      valid_d = 1'b1;
      char_d  = load_sym_i;
      row_d   = '0;
    end
    if (clear_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    row_q  <= row_d;
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/lcs_chk.sv
// ----------------------------------------------------------------------------
// lcs_chk: port-level checks for the LCS length engine
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lcs_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import lcs_pkg::*;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (s_axis_tuser == MODE_FINISH) |=> m_axis_tvalid)
    else $error("finish request gave no result");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'(MAX_LEN)))
    else $error("length beyond string capacity");

  a_drain_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (s_axis_tuser == MODE_PROC) |=>
      !(s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_FINISH))
    else $error("finish taken while a wavefront is in flight");

endmodule

bind lcs_length_engine_top lcs_chk u_lcs_chk (.*);
